// File: rtl/sjl_pkg.sv
// Package for the stepper jog/limit controller: phase and movement codes,
// the input and result item structs, and the phase encoding helper.
// No dependencies.
`timescale 1ns / 1ps

package sjl_pkg;

    localparam int unsigned IN_POS_W  = 16;
    localparam int unsigned SETTLE_W  = 8;
    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned MOVE_W    = 2;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd20;

    // Phase codes as they appear on the result channel.
    localparam logic [PHASE_W-1:0] PH_CODE_SEEK_BOTTOM   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CODE_SETTLE_BOTTOM = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CODE_SEEK_TOP      = 3'd2;
    localparam logic [PHASE_W-1:0] PH_CODE_SETTLE_TOP    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CODE_RUN           = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CODE_FAILED        = 3'd5;
    localparam logic [PHASE_W-1:0] PH_CODE_STOPPED       = 3'd6;

    // Movement codes.
    localparam logic [MOVE_W-1:0] MOV_STOP = 2'd0;
    localparam logic [MOVE_W-1:0] MOV_UP   = 2'd1;
    localparam logic [MOVE_W-1:0] MOV_DOWN = 2'd2;
    localparam logic [MOVE_W-1:0] MOV_FREE = 2'd3;

    typedef enum logic [6:0] {
        PH_SEEK_BOTTOM   = 7'b0000001,
        PH_SETTLE_BOTTOM = 7'b0000010,
        PH_SEEK_TOP      = 7'b0000100,
        PH_SETTLE_TOP    = 7'b0001000,
        PH_RUN           = 7'b0010000,
        PH_FAILED        = 7'b0100000,
        PH_STOPPED       = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic                       up_pressed;
        logic                       down_pressed;
        logic                       trim_switch_closed;
        logic                       top_switch;
        logic                       bottom_switch;
        logic                       hydraulic_failure;
        logic signed [IN_POS_W-1:0] position;
        logic                       stop_request;
    } sjl_in_t;

    typedef struct packed {
        logic                       motor_free;
        logic                       step_dir;
        logic                       step_pulse;
        logic [MOVE_W-1:0]          movement;
        logic [PHASE_W-1:0]         phase_code;
        logic signed [IN_POS_W-1:0] top_out;
        logic signed [IN_POS_W-1:0] bottom_out;
        logic                       is_calibrated;
    } sjl_out_t;

    function automatic logic [PHASE_W-1:0] phase_to_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_SEEK_BOTTOM:   code = PH_CODE_SEEK_BOTTOM;
            PH_SETTLE_BOTTOM: code = PH_CODE_SETTLE_BOTTOM;
            PH_SEEK_TOP:      code = PH_CODE_SEEK_TOP;
            PH_SETTLE_TOP:    code = PH_CODE_SETTLE_TOP;
            PH_RUN:           code = PH_CODE_RUN;
            PH_FAILED:        code = PH_CODE_FAILED;
            PH_STOPPED:       code = PH_CODE_STOPPED;
            default:          code = PH_CODE_STOPPED;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/stepper_jog_limit_controller_unit.sv
// Top level of the stepper jog/limit controller: input register, decision
// stage, result register and the settle-time register.
// Depends on sjl_pkg, sjl_in_stage, sjl_core and sjl_out_stage.
`timescale 1ns / 1ps

// Usage:
// Each item on the s_ channel is one control tick: buttons, limit switches,
// trim switch, hydraulic failure flag, position reading and stop request.
// Every item yields exactly one result item on the m_ channel with the motor
// enable and direction levels, the step pulse, the movement code, the phase
// after the tick and the calibrated limit positions.
// An accepted item lands in the input register; the decision logic then
// evaluates it combinationally against the controller state, and the result
// is written into the output register once that register has room.
// Throughput is one item per cycle while the receiver keeps m_ready high, set by
// the single registered decision stage whose state updates once per item.
// When the receiver stalls, the result register holds its item and the input
// register fills; after that s_ready drops until m_ready returns.
// Reset (aresetn low, synchronous) empties both registers, puts the block in
// the seek-bottom phase with the motor engaged, and sets settle_ticks to 20.
// The cfg_ channel writes settle_ticks; it is always ready and should only be
// written while no items are in flight.
module stepper_jog_limit_controller_unit #(
    parameter int unsigned POS_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_up_pressed,
    input  logic        s_down_pressed,
    input  logic        s_trim_switch_closed,
    input  logic        s_top_switch,
    input  logic        s_bottom_switch,
    input  logic        s_hydraulic_failure,
    input  logic signed [15:0] s_position,
    input  logic        s_stop_request,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_motor_free,
    output logic        m_step_dir,
    output logic        m_step_pulse,
    output logic [1:0]  m_movement,
    output logic [2:0]  m_phase_code,
    output logic signed [15:0] m_top_out,
    output logic signed [15:0] m_bottom_out,
    output logic        m_is_calibrated
);
    import sjl_pkg::*;

    sjl_in_t             in_item;
    sjl_in_t             item;
    logic                item_valid;
    logic                out_room;
    logic                advance;
    sjl_out_t            result;
    sjl_out_t            out_item;
    logic [SETTLE_W-1:0] settle_ticks_reg;

    // Settle-time register. Writes are accepted in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ticks_reg <= SETTLE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            settle_ticks_reg <= cfg_data;
        end
    end

    always_comb begin
        in_item.up_pressed         = s_up_pressed;
        in_item.down_pressed       = s_down_pressed;
        in_item.trim_switch_closed = s_trim_switch_closed;
        in_item.top_switch         = s_top_switch;
        in_item.bottom_switch      = s_bottom_switch;
        in_item.hydraulic_failure  = s_hydraulic_failure;
        in_item.position           = s_position;
        in_item.stop_request       = s_stop_request;
    end

    // The decision stage fires whenever an item is waiting and the result
    // register can take its result in the same cycle.
    assign advance = item_valid && out_room;

    sjl_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (advance),
        .item       (item)
    );

    sjl_core #(
        .POS_WIDTH (POS_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .item         (item),
        .settle_ticks (settle_ticks_reg),
        .result       (result)
    );

    sjl_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .load_ready (out_room),
        .load_item  (result),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_item   (out_item)
    );

    assign m_motor_free    = out_item.motor_free;
    assign m_step_dir      = out_item.step_dir;
    assign m_step_pulse    = out_item.step_pulse;
    assign m_movement      = out_item.movement;
    assign m_phase_code    = out_item.phase_code;
    assign m_top_out       = out_item.top_out;
    assign m_bottom_out    = out_item.bottom_out;
    assign m_is_calibrated = out_item.is_calibrated;

    // Every decision produces a result item in the next cycle.
    a_advance_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid
    ) else $error("decision fired but no result item followed");

    // A step is only ever issued with the motor engaged and a real move.
    a_pulse_engaged: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_step_pulse) |->
            (!m_motor_free && (m_movement == MOV_UP || m_movement == MOV_DOWN))
    ) else $error("step pulse with released motor or without movement");

    // A successful calibration never reports equal limit positions.
    a_calib_distinct: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_calibrated) |-> (m_top_out != m_bottom_out)
    ) else $error("calibrated with equal top and bottom positions");

    // Terminal phases report a released, idle motor.
    a_terminal_idle: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_phase_code == PH_CODE_FAILED || m_phase_code == PH_CODE_STOPPED))
            |-> (m_motor_free && !m_step_pulse && m_movement == MOV_STOP)
    ) else $error("terminal phase with motor engaged or moving");

endmodule

// File: rtl/sjl_in_stage.sv
// Input register of the controller: holds one accepted tick item until the
// decision stage consumes it. Depends on sjl_pkg.
`timescale 1ns / 1ps

module sjl_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sjl_pkg::sjl_in_t in_item,
    output logic             item_valid,
    input  logic             item_take,
    output sjl_pkg::sjl_in_t item
);
    import sjl_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    sjl_in_t data_reg;

    // The register frees up in the same cycle its item is consumed.
    assign in_ready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (item_take) begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

// File: rtl/sjl_core.sv
// Decision stage: calibration and run-mode state, and the per-tick result.
// Depends on sjl_pkg.
`timescale 1ns / 1ps

module sjl_core #(
    parameter int unsigned POS_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  sjl_pkg::sjl_in_t                item,
    input  logic [sjl_pkg::SETTLE_W-1:0]    settle_ticks,
    output sjl_pkg::sjl_out_t               result
);
    import sjl_pkg::*;

    localparam int unsigned EXT_W = 32;

    phase_t                phase_reg, phase_next;
    logic [SETTLE_W-1:0]   settle_count_reg, settle_count_next;
    logic [POS_WIDTH-1:0]  bottom_pos_reg, bottom_pos_next;
    logic [POS_WIDTH-1:0]  top_pos_reg, top_pos_next;
    logic                  calibrated_reg, calibrated_next;
    logic                  dir_level_reg, dir_level_next;
    logic                  free_level_reg, free_level_next;

    logic [EXT_W-1:0]      pos_ext;
    logic [POS_WIDTH-1:0]  pos_w;
    logic                  pulse;
    logic [MOVE_W-1:0]     move;
    logic [EXT_W-1:0]      top_ext;
    logic [EXT_W-1:0]      bottom_ext;

    // Sign-extend the reading, then keep the stored position width.
    assign pos_ext = {{(EXT_W-IN_POS_W){item.position[IN_POS_W-1]}}, item.position};
    assign pos_w   = pos_ext[POS_WIDTH-1:0];

    always_comb begin
        phase_next        = phase_reg;
        settle_count_next = settle_count_reg;
        bottom_pos_next   = bottom_pos_reg;
        top_pos_next      = top_pos_reg;
        calibrated_next   = calibrated_reg;
        dir_level_next    = dir_level_reg;
        free_level_next   = free_level_reg;
        pulse             = 1'b0;
        move              = MOV_STOP;

        if (phase_reg == PH_FAILED || phase_reg == PH_STOPPED) begin
            free_level_next = 1'b1;
        end else if (item.stop_request) begin
            free_level_next = 1'b1;
            phase_next      = PH_STOPPED;
        end else begin
            case (phase_reg)
                PH_SEEK_BOTTOM: begin
                    if (!item.bottom_switch) begin
                        pulse          = 1'b1;
                        dir_level_next = 1'b0;
                        move           = MOV_UP;
                    end else begin
                        phase_next        = PH_SETTLE_BOTTOM;
                        settle_count_next = '0;
                    end
                end
                PH_SEEK_TOP: begin
                    if (!item.top_switch) begin
                        pulse          = 1'b1;
                        dir_level_next = 1'b1;
                        move           = MOV_DOWN;
                    end else begin
                        phase_next        = PH_SETTLE_TOP;
                        settle_count_next = '0;
                    end
                end
                PH_SETTLE_BOTTOM: begin
                    if (settle_count_reg < settle_ticks) begin
                        settle_count_next = settle_count_reg + 1'b1;
                    end else begin
                        bottom_pos_next = pos_w;
                        phase_next      = PH_SEEK_TOP;
                    end
                end
                PH_SETTLE_TOP: begin
                    if (settle_count_reg < settle_ticks) begin
                        settle_count_next = settle_count_reg + 1'b1;
                    end else begin
                        top_pos_next = pos_w;
                        if (pos_w == bottom_pos_reg) begin
                            phase_next      = PH_FAILED;
                            free_level_next = 1'b1;
                        end else begin
                            calibrated_next = 1'b1;
                            phase_next      = PH_RUN;
                        end
                    end
                end
                PH_RUN: begin
                    if (item.hydraulic_failure) begin
                        free_level_next = 1'b0;
                        if (!item.top_switch) begin
                            pulse          = 1'b1;
                            dir_level_next = 1'b1;
                            move           = MOV_DOWN;
                        end
                    end else if (!item.trim_switch_closed) begin
                        free_level_next = 1'b1;
                        move            = MOV_FREE;
                    end else begin
                        free_level_next = 1'b0;
                        if (item.up_pressed && !item.down_pressed) begin
                            if (!item.bottom_switch) begin
                                pulse          = 1'b1;
                                dir_level_next = 1'b0;
                                move           = MOV_UP;
                            end
                        end else if (item.down_pressed && !item.up_pressed) begin
                            if (!item.top_switch) begin
                                pulse          = 1'b1;
                                dir_level_next = 1'b1;
                                move           = MOV_DOWN;
                            end
                        end
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SEEK_BOTTOM;
            settle_count_reg <= '0;
            bottom_pos_reg   <= '0;
            top_pos_reg      <= '0;
            calibrated_reg   <= 1'b0;
            dir_level_reg    <= 1'b0;
            free_level_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg        <= phase_next;
            settle_count_reg <= settle_count_next;
            bottom_pos_reg   <= bottom_pos_next;
            top_pos_reg      <= top_pos_next;
            calibrated_reg   <= calibrated_next;
            dir_level_reg    <= dir_level_next;
            free_level_reg   <= free_level_next;
        end
    end

    // Stored positions are reported zero-extended and cut to the port width.
    assign top_ext    = EXT_W'(top_pos_next);
    assign bottom_ext = EXT_W'(bottom_pos_next);

    always_comb begin
        result.motor_free    = free_level_next;
        result.step_dir      = dir_level_next;
        result.step_pulse    = pulse;
        result.movement      = move;
        result.phase_code    = phase_to_code(phase_next);
        result.top_out       = calibrated_next ? top_ext[IN_POS_W-1:0] : '0;
        result.bottom_out    = calibrated_next ? bottom_ext[IN_POS_W-1:0] : '0;
        result.is_calibrated = calibrated_next;
    end

endmodule

// File: rtl/sjl_out_stage.sv
// Result register of the controller: holds one result item until the
// receiver takes it. Depends on sjl_pkg.
`timescale 1ns / 1ps

module sjl_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    output logic              load_ready,
    input  sjl_pkg::sjl_out_t load_item,
    output logic              out_valid,
    input  logic              out_ready,
    output sjl_pkg::sjl_out_t out_item
);
    import sjl_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    sjl_out_t data_reg;

    assign load_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = data_reg;

endmodule
